// ----- rtl/icp_pkg.sv -----
// Shared types and constants for the IRC formatting code parser.
package icp_pkg;

	localparam int unsigned PALETTE_ENTRIES = 16;
	localparam int unsigned PAL_IDX_W       = 4;
	localparam int unsigned CHAR_W          = 16;
	localparam int unsigned COLOR_W         = 32;

	localparam logic [COLOR_W-1:0] COLOR_INVALID = 32'hFFFF_FFFF;

	localparam logic [CHAR_W-1:0] CODE_BOLD      = 16'd2;
	localparam logic [CHAR_W-1:0] CODE_COLOR     = 16'd3;
	localparam logic [CHAR_W-1:0] CODE_PLAIN     = 16'd15;
	localparam logic [CHAR_W-1:0] CODE_RESET     = 16'd22;
	localparam logic [CHAR_W-1:0] CODE_UNDERLINE = 16'd31;
	localparam logic [CHAR_W-1:0] CH_LF          = 16'd10;
	localparam logic [CHAR_W-1:0] CH_CR          = 16'd13;
	localparam logic [CHAR_W-1:0] CH_COMMA       = 16'h2C;
	localparam logic [CHAR_W-1:0] CH_ZERO        = 16'h30;
	localparam logic [CHAR_W-1:0] CH_NINE        = 16'h39;

	localparam logic CMD_TEXT    = 1'b0;
	localparam logic CMD_PALETTE = 1'b1;

	typedef enum logic [6:0] {
		PH_NORMAL   = 7'b0000001,
		PH_CR       = 7'b0000010,
		PH_FG1      = 7'b0000100,
		PH_FG2      = 7'b0001000,
		PH_AFTER_FG = 7'b0010000,
		PH_BG1      = 7'b0100000,
		PH_BG2      = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic                 command;
		logic [CHAR_W-1:0]    char_code;
		logic                 last_char;
		logic [PAL_IDX_W-1:0] palette_index;
		logic [COLOR_W-1:0]   palette_color;
	} item_t;

	typedef struct packed {
		logic [CHAR_W-1:0]  out_char;
		logic               bold_on;
		logic               underline_on;
		logic               fg_enable;
		logic [COLOR_W-1:0] fg_color;
		logic               bg_enable;
		logic [COLOR_W-1:0] bg_color;
		logic               run_end;
	} result_t;

	typedef struct packed {
		logic               bold;
		logic               underline;
		logic               fg_en;
		logic [COLOR_W-1:0] fg_color;
		logic               bg_en;
		logic [COLOR_W-1:0] bg_color;
	} attr_t;

	// one or two results of a single item, all with the same attributes
	typedef struct packed {
		attr_t             attr;
		logic [CHAR_W-1:0] ch0;
		logic [CHAR_W-1:0] ch1;
		logic              two;
	} run_t;

endpackage

// ----- rtl/irc_format_code_parser_core.sv -----
// An accepted item's results are written into the run queue and read from its head.
// One item per cycle is accepted while the run queue is not full; one result per cycle
// leaves it while it is not empty and pop is high. An item with two results (held CR)
// gives them out one after the other. Palette writes and formatting codes produce no result.
// Reset clears attributes and parse state, zeroes the palette, sets CR LF reset on.
// Top level of the IRC formatting code parser.
module irc_format_code_parser_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  icp_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output icp_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_data
);

	logic          accept;
	logic          run_push;
	logic          run_pop;
	icp_pkg::run_t run_in;
	icp_pkg::run_t run_out;

	assign accept    = push && !full;
	assign cfg_ready = 1'b1;

	icp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.run_push (run_push),
		.run      (run_in)
	);

	icp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (run_push),
		.wr_data (run_in),
		.rd_en   (run_pop),
		.rd_data (run_out),
		.full    (full),
		.empty   (empty)
	);

	icp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.run       (run_out),
		.run_empty (empty),
		.run_pop   (run_pop),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ----- rtl/icp_front.sv -----
// Front end: parses formatting codes, holds attributes, palette and config.
module icp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  icp_pkg::item_t item,
	input  logic          cfg_we,
	input  logic          cfg_data,
	output logic          run_push,
	output icp_pkg::run_t run
);

	logic [icp_pkg::COLOR_W-1:0] pal_q [icp_pkg::PALETTE_ENTRIES];
	icp_pkg::attr_t  attr_q;
	icp_pkg::phase_t phase_q;
	logic [3:0]      acc_q;
	logic            crlf_en_q;

	icp_pkg::attr_t  a;
	icp_pkg::phase_t ph;
	logic [3:0]      acc;
	logic [1:0]      cnt;
	logic [icp_pkg::CHAR_W-1:0] ch0;
	logic [icp_pkg::CHAR_W-1:0] ch1;
	logic            do_plain;
	logic            hold_attr;
	logic            is_digit;
	logic            is_comma;
	logic [icp_pkg::CHAR_W-1:0] c;
	logic [7:0]      two_digit;
	logic [icp_pkg::PAL_IDX_W-1:0] lk_idx;
	logic [icp_pkg::COLOR_W-1:0]   lk_color;
	logic            text_acc;

	assign c         = item.char_code;
	assign is_digit  = (c >= icp_pkg::CH_ZERO) && (c <= icp_pkg::CH_NINE);
	assign is_comma  = (c == icp_pkg::CH_COMMA);
	assign two_digit = 8'(acc_q) * 8'd10 + 8'(c[3:0]);
	assign lk_idx    = is_digit ? two_digit[icp_pkg::PAL_IDX_W-1:0] : acc_q;
	assign lk_color  = pal_q[lk_idx];
	assign text_acc  = accept && (item.command == icp_pkg::CMD_TEXT);

	always_comb begin
		a         = attr_q;
		ph        = phase_q;
		acc       = acc_q;
		cnt       = 2'd0;
		ch0       = c;
		ch1       = c;
		do_plain  = 1'b0;
		hold_attr = 1'b0;

		unique case (phase_q)
			icp_pkg::PH_CR: begin
				ph = icp_pkg::PH_NORMAL;
				if (c == icp_pkg::CH_LF) begin
					a.bold      = 1'b0;
					a.underline = 1'b0;
					a.fg_color  = icp_pkg::COLOR_INVALID;
					a.bg_color  = icp_pkg::COLOR_INVALID;
					ch0         = icp_pkg::CH_LF;
					cnt         = 2'd1;
				end else begin
					// held CR goes out with the attributes it arrived under
					ch0       = icp_pkg::CH_CR;
					cnt       = 2'd1;
					do_plain  = 1'b1;
					hold_attr = 1'b1;
				end
			end
			icp_pkg::PH_FG1: begin
				if (is_digit) begin
					acc = c[3:0];
					ph  = icp_pkg::PH_FG2;
				end else begin
					a.fg_en  = 1'b0;
					a.bg_en  = 1'b0;
					do_plain = 1'b1;
				end
			end
			icp_pkg::PH_FG2: begin
				a.fg_en    = 1'b1;
				a.fg_color = lk_color;
				if (is_digit) begin
					ph = icp_pkg::PH_AFTER_FG;
				end else if (is_comma) begin
					ph = icp_pkg::PH_BG1;
				end else begin
					do_plain = 1'b1;
				end
			end
			icp_pkg::PH_AFTER_FG: begin
				if (is_comma) begin
					ph = icp_pkg::PH_BG1;
				end else begin
					do_plain = 1'b1;
				end
			end
			icp_pkg::PH_BG1: begin
				if (is_digit) begin
					acc = c[3:0];
					ph  = icp_pkg::PH_BG2;
				end else begin
					do_plain = 1'b1;
				end
			end
			icp_pkg::PH_BG2: begin
				a.bg_en    = 1'b1;
				a.bg_color = lk_color;
				if (is_digit) begin
					ph = icp_pkg::PH_NORMAL;
				end else begin
					do_plain = 1'b1;
				end
			end
			default: begin
				do_plain = 1'b1;
			end
		endcase

		if (do_plain) begin
			ph = icp_pkg::PH_NORMAL;
			unique case (c)
				icp_pkg::CODE_BOLD:      a.bold = ~a.bold;
				icp_pkg::CODE_COLOR:     ph = icp_pkg::PH_FG1;
				icp_pkg::CODE_PLAIN: begin
					a.bold      = 1'b0;
					a.underline = 1'b0;
					a.fg_color  = icp_pkg::COLOR_INVALID;
					a.bg_color  = icp_pkg::COLOR_INVALID;
				end
				icp_pkg::CODE_RESET: begin
					a.bold      = 1'b0;
					a.underline = 1'b0;
				end
				icp_pkg::CODE_UNDERLINE: a.underline = ~a.underline;
				default: begin
					if (c == icp_pkg::CH_CR && crlf_en_q) begin
						ph = icp_pkg::PH_CR;
					end else if (cnt == 2'd0) begin
						ch0 = c;
						cnt = 2'd1;
					end else begin
						ch1 = c;
						cnt = 2'd2;
					end
				end
			endcase
		end

		// held CR flushed at end of string
		if (item.last_char && ph == icp_pkg::PH_CR) begin
			if (cnt == 2'd0) begin
				ch0 = icp_pkg::CH_CR;
				cnt = 2'd1;
			end else begin
				ch1 = icp_pkg::CH_CR;
				cnt = 2'd2;
			end
		end
	end

	assign run_push = text_acc && (cnt != 2'd0);
	assign run.attr = hold_attr ? attr_q : a;
	assign run.ch0  = ch0;
	assign run.ch1  = ch1;
	assign run.two  = (cnt == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < icp_pkg::PALETTE_ENTRIES; i++) begin
				pal_q[i] <= '0;
			end
			attr_q.bold      <= 1'b0;
			attr_q.underline <= 1'b0;
			attr_q.fg_en     <= 1'b1;
			attr_q.fg_color  <= '0;
			attr_q.bg_en     <= 1'b0;
			attr_q.bg_color  <= '0;
			phase_q          <= icp_pkg::PH_NORMAL;
			acc_q            <= '0;
			crlf_en_q        <= 1'b1;
		end else begin
			if (cfg_we) begin
				crlf_en_q <= cfg_data;
			end
			if (accept && item.command == icp_pkg::CMD_PALETTE) begin
				pal_q[item.palette_index] <= item.palette_color;
			end
			if (text_acc) begin
				if (item.last_char) begin
					attr_q.bold      <= 1'b0;
					attr_q.underline <= 1'b0;
					attr_q.fg_en     <= 1'b1;
					attr_q.fg_color  <= '0;
					attr_q.bg_en     <= 1'b0;
					attr_q.bg_color  <= '0;
					phase_q          <= icp_pkg::PH_NORMAL;
					acc_q            <= '0;
				end else begin
					attr_q  <= a;
					phase_q <= ph;
					acc_q   <= acc;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		text_acc && item.last_char |=> phase_q == icp_pkg::PH_NORMAL && !attr_q.bold)
		else $error("parse state not cleared after last character");
	a_palette_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.command == icp_pkg::CMD_PALETTE |-> !run_push)
		else $error("palette write produced a result");
`endif

endmodule

// ----- rtl/icp_queue.sv -----
// Short run queue between the parser front end and the result back end.
module icp_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  icp_pkg::run_t wr_data,
	input  logic          rd_en,
	output icp_pkg::run_t rd_data,
	output logic          full,
	output logic          empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	icp_pkg::run_t      mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a write");
`endif

endmodule

// ----- rtl/icp_back.sv -----
// Back end: splits each queued run into one or two result items.
module icp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  icp_pkg::run_t    run,
	input  logic             run_empty,
	output logic             run_pop,
	input  logic             pop,
	output icp_pkg::result_t result
);

	logic sel_q;
	logic take;

	assign take    = pop && !run_empty;
	assign run_pop = take && (!run.two || sel_q);

	assign result.out_char     = sel_q ? run.ch1 : run.ch0;
	assign result.bold_on      = run.attr.bold;
	assign result.underline_on = run.attr.underline;
	assign result.fg_enable    = run.attr.fg_en;
	assign result.fg_color     = run.attr.fg_color;
	assign result.bg_enable    = run.attr.bg_en;
	assign result.bg_color     = run.attr.bg_color;
	assign result.run_end      = sel_q || !run.two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (take) begin
			sel_q <= run.two && !sel_q;
		end
	end

`ifndef SYNTHESIS
	a_second_only_in_pair: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> !run_empty && run.two)
		else $error("second result selected without a pair");
`endif

endmodule
